// ===== rtl/kf_pkg.sv =====
// ----------------------------------------------------------------------------
// kf_pkg
// Shared types, constants, micro-op table and saturation helper for the
// two-state scalar-measurement Kalman filter.
// ----------------------------------------------------------------------------
package kf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int ACC_W     = 64 - FRAC_BITS + 2;
    localparam int DIV_W     = DW + FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int SEL_W     = 6;
    localparam int PC_W      = 5;

    localparam logic signed [DW-1:0] ONE      = DW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [DW-1:0] INIT_RST = DW'(64'sd100 <<< FRAC_BITS);

    // configuration register indexes
    localparam logic [2:0] CFG_F00  = 3'd0;
    localparam logic [2:0] CFG_F01  = 3'd1;
    localparam logic [2:0] CFG_F10  = 3'd2;
    localparam logic [2:0] CFG_F11  = 3'd3;
    localparam logic [2:0] CFG_H0   = 3'd4;
    localparam logic [2:0] CFG_H1   = 3'd5;
    localparam logic [2:0] CFG_R    = 3'd6;
    localparam logic [2:0] CFG_INIT = 3'd7;

    // operand selects
    localparam logic [SEL_W-1:0] S_F00  = 6'd0;
    localparam logic [SEL_W-1:0] S_F01  = 6'd1;
    localparam logic [SEL_W-1:0] S_F10  = 6'd2;
    localparam logic [SEL_W-1:0] S_F11  = 6'd3;
    localparam logic [SEL_W-1:0] S_H0   = 6'd4;
    localparam logic [SEL_W-1:0] S_H1   = 6'd5;
    localparam logic [SEL_W-1:0] S_R    = 6'd6;
    localparam logic [SEL_W-1:0] S_Z    = 6'd7;
    localparam logic [SEL_W-1:0] S_X0   = 6'd8;
    localparam logic [SEL_W-1:0] S_X1   = 6'd9;
    localparam logic [SEL_W-1:0] S_P0   = 6'd10;
    localparam logic [SEL_W-1:0] S_P1   = 6'd11;
    localparam logic [SEL_W-1:0] S_P2   = 6'd12;
    localparam logic [SEL_W-1:0] S_P3   = 6'd13;
    localparam logic [SEL_W-1:0] S_XP0  = 6'd14;
    localparam logic [SEL_W-1:0] S_XP1  = 6'd15;
    localparam logic [SEL_W-1:0] S_A0   = 6'd16;
    localparam logic [SEL_W-1:0] S_A1   = 6'd17;
    localparam logic [SEL_W-1:0] S_A2   = 6'd18;
    localparam logic [SEL_W-1:0] S_A3   = 6'd19;
    localparam logic [SEL_W-1:0] S_PP0  = 6'd20;
    localparam logic [SEL_W-1:0] S_PP1  = 6'd21;
    localparam logic [SEL_W-1:0] S_PP2  = 6'd22;
    localparam logic [SEL_W-1:0] S_PP3  = 6'd23;
    localparam logic [SEL_W-1:0] S_HP0  = 6'd24;
    localparam logic [SEL_W-1:0] S_HP1  = 6'd25;
    localparam logic [SEL_W-1:0] S_C0   = 6'd26;
    localparam logic [SEL_W-1:0] S_C1   = 6'd27;
    localparam logic [SEL_W-1:0] S_S    = 6'd28;
    localparam logic [SEL_W-1:0] S_Y    = 6'd29;
    localparam logic [SEL_W-1:0] S_K0   = 6'd30;
    localparam logic [SEL_W-1:0] S_K1   = 6'd31;
    localparam logic [SEL_W-1:0] S_ZERO = 6'd32;

    // micro-op codes
    localparam logic [2:0] OP_DOT = 3'd0;
    localparam logic [2:0] OP_CHK = 3'd1;
    localparam logic [2:0] OP_DIV = 3'd2;
    localparam logic [2:0] OP_END = 3'd3;

    typedef struct packed {
        logic [2:0]       op;
        logic [SEL_W-1:0] a0;
        logic [SEL_W-1:0] b0;
        logic [SEL_W-1:0] a1;
        logic [SEL_W-1:0] b1;
        logic [SEL_W-1:0] e;
        logic [SEL_W-1:0] dst;
        logic             neg;
    } t_uop;

    typedef struct packed {
        logic             mul;
        logic             ld;
        logic             add;
        logic             wr;
        logic             neg;
        logic             div_start;
        logic             ld_z;
        logic             ld_out;
        logic             bad;
        logic [SEL_W-1:0] sa;
        logic [SEL_W-1:0] sb;
        logic [SEL_W-1:0] se;
        logic [SEL_W-1:0] dst;
    } t_cmd;

    typedef struct packed {
        logic s_bad;
        logic div_done;
    } t_stat;

    function automatic t_uop mk(input logic [2:0] op,
                                input logic [SEL_W-1:0] a0, input logic [SEL_W-1:0] b0,
                                input logic [SEL_W-1:0] a1, input logic [SEL_W-1:0] b1,
                                input logic [SEL_W-1:0] e, input logic [SEL_W-1:0] dst,
                                input logic neg);
        t_uop u;
        u.op = op; u.a0 = a0; u.b0 = b0; u.a1 = a1; u.b1 = b1;
        u.e = e; u.dst = dst; u.neg = neg;
        return u;
    endfunction

    // dst = sat(e +/- sat(a0*b0 + a1*b1))
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        u = mk(OP_END, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
        unique case (pc)
            5'd0:  u = mk(OP_DOT, S_F00, S_X0, S_F01, S_X1, S_ZERO, S_XP0, 1'b0);
            5'd1:  u = mk(OP_DOT, S_F10, S_X0, S_F11, S_X1, S_ZERO, S_XP1, 1'b0);
            5'd2:  u = mk(OP_DOT, S_F00, S_P0, S_F01, S_P2, S_ZERO, S_A0, 1'b0);
            5'd3:  u = mk(OP_DOT, S_F00, S_P1, S_F01, S_P3, S_ZERO, S_A1, 1'b0);
            5'd4:  u = mk(OP_DOT, S_F10, S_P0, S_F11, S_P2, S_ZERO, S_A2, 1'b0);
            5'd5:  u = mk(OP_DOT, S_F10, S_P1, S_F11, S_P3, S_ZERO, S_A3, 1'b0);
            5'd6:  u = mk(OP_DOT, S_A0, S_F00, S_A1, S_F01, S_ZERO, S_PP0, 1'b0);
            5'd7:  u = mk(OP_DOT, S_A0, S_F10, S_A1, S_F11, S_ZERO, S_PP1, 1'b0);
            5'd8:  u = mk(OP_DOT, S_A2, S_F00, S_A3, S_F01, S_ZERO, S_PP2, 1'b0);
            5'd9:  u = mk(OP_DOT, S_A2, S_F10, S_A3, S_F11, S_ZERO, S_PP3, 1'b0);
            5'd10: u = mk(OP_DOT, S_H0, S_PP0, S_H1, S_PP2, S_ZERO, S_HP0, 1'b0);
            5'd11: u = mk(OP_DOT, S_H0, S_PP1, S_H1, S_PP3, S_ZERO, S_HP1, 1'b0);
            5'd12: u = mk(OP_DOT, S_PP0, S_H0, S_PP1, S_H1, S_ZERO, S_C0, 1'b0);
            5'd13: u = mk(OP_DOT, S_PP2, S_H0, S_PP3, S_H1, S_ZERO, S_C1, 1'b0);
            5'd14: u = mk(OP_DOT, S_HP0, S_H0, S_HP1, S_H1, S_R, S_S, 1'b0);
            5'd15: u = mk(OP_DOT, S_H0, S_XP0, S_H1, S_XP1, S_Z, S_Y, 1'b1);
            5'd16: u = mk(OP_CHK, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
            5'd17: u = mk(OP_DIV, S_C0, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_K0, 1'b0);
            5'd18: u = mk(OP_DIV, S_C1, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_K1, 1'b0);
            5'd19: u = mk(OP_DOT, S_K0, S_Y, S_ZERO, S_ZERO, S_XP0, S_X0, 1'b0);
            5'd20: u = mk(OP_DOT, S_K1, S_Y, S_ZERO, S_ZERO, S_XP1, S_X1, 1'b0);
            5'd21: u = mk(OP_DOT, S_K0, S_HP0, S_ZERO, S_ZERO, S_PP0, S_P0, 1'b1);
            5'd22: u = mk(OP_DOT, S_K0, S_HP1, S_ZERO, S_ZERO, S_PP1, S_P1, 1'b1);
            5'd23: u = mk(OP_DOT, S_K1, S_HP0, S_ZERO, S_ZERO, S_PP2, S_P2, 1'b1);
            5'd24: u = mk(OP_DOT, S_K1, S_HP1, S_ZERO, S_ZERO, S_PP3, S_P3, 1'b1);
            default: u = mk(OP_END, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
        endcase
        return u;
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32'sh7FFF_FFFF);
        lo = ACC_W'($signed(32'h8000_0000));
        if (v > hi) begin
            return DW'(hi);
        end else if (v < lo) begin
            return DW'(lo);
        end
        return DW'(v);
    endfunction

endpackage

// ===== rtl/kf_div.sv =====
// ----------------------------------------------------------------------------
// kf_div
// Restoring divider, one quotient bit a cycle: round(c * 2^FRAC / s), ties
// away from zero, saturated to 32 bits signed. s must be positive.
// ----------------------------------------------------------------------------
module kf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [kf_pkg::DW-1:0]  i_num,
    input  logic signed [kf_pkg::DW-1:0]  i_den,
    output logic                          o_done,
    output logic signed [kf_pkg::DW-1:0]  o_quot
);

    logic [kf_pkg::CNT_W-1:0] r_cnt;
    logic                     r_done;
    logic                     r_neg;
    logic [kf_pkg::DIV_W-1:0] r_div;
    logic [kf_pkg::DIV_W-1:0] r_q;
    logic [kf_pkg::DW-2:0]    r_rem;
    logic [kf_pkg::DW-1:0]    r_den;

    logic [kf_pkg::DW-1:0]    w_mag;
    logic [kf_pkg::DIV_W-1:0] w_dividend;
    logic [kf_pkg::DW-1:0]    w_trial;
    logic                     w_ge;
    logic [kf_pkg::DIV_W-1:0] w_cap;
    logic [kf_pkg::DW-1:0]    w_qs;

    assign w_mag      = i_num[kf_pkg::DW-1] ? (kf_pkg::DW'(0) - i_num) : i_num;
    assign w_dividend = kf_pkg::DIV_W'({w_mag, {kf_pkg::FRAC_BITS{1'b0}}})
                      + kf_pkg::DIV_W'(i_den >> 1);
    assign w_trial    = {r_rem, r_div[kf_pkg::DIV_W-1]};
    assign w_ge       = (w_trial >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= kf_pkg::CNT_W'(kf_pkg::DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == kf_pkg::CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[kf_pkg::DW-1];
            r_div <= w_dividend;
            r_q   <= '0;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_div <= {r_div[kf_pkg::DIV_W-2:0], 1'b0};
            r_q   <= {r_q[kf_pkg::DIV_W-2:0], w_ge};
            r_rem <= w_ge ? (kf_pkg::DW-1)'(w_trial - r_den) : w_trial[kf_pkg::DW-2:0];
        end
    end

    assign w_cap  = r_neg ? kf_pkg::DIV_W'(32'h8000_0000) : kf_pkg::DIV_W'(32'h7FFF_FFFF);
    assign w_qs   = (r_q > w_cap) ? w_cap[kf_pkg::DW-1:0] : r_q[kf_pkg::DW-1:0];
    assign o_quot = r_neg ? $signed(kf_pkg::DW'(0) - w_qs) : $signed(w_qs);
    assign o_done = r_done;

endmodule

// ===== rtl/kf_datapath.sv =====
// ----------------------------------------------------------------------------
// kf_datapath
// Operand registers, shared 32x32 multiplier, rounding accumulator,
// saturating write-back, divider and result register.
// ----------------------------------------------------------------------------
module kf_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kf_pkg::t_cmd                  i_cmd,
    output kf_pkg::t_stat                 o_stat,
    input  logic                          i_cfg_wr_en,
    input  logic [2:0]                    i_cfg_addr,
    input  logic [kf_pkg::DW-1:0]         i_cfg_wdata,
    input  logic signed [kf_pkg::DW-1:0]  i_sample,
    output logic [6*kf_pkg::DW-1:0]       o_res,
    output logic                          o_bad
);

    logic signed [kf_pkg::DW-1:0]    r_rf [32];
    logic signed [63:0]              r_prod;
    logic signed [kf_pkg::ACC_W-1:0] r_acc;
    logic [kf_pkg::SEL_W-1:0]        r_div_dst;
    logic [6*kf_pkg::DW-1:0]         r_res;
    logic                            r_bad;

    logic signed [kf_pkg::DW-1:0]    w_opa, w_opb, w_ope;
    logic signed [63:0]              w_rnd64;
    logic signed [kf_pkg::ACC_W-1:0] w_rnd;
    logic signed [kf_pkg::DW-1:0]    w_v;
    logic signed [kf_pkg::DW:0]      w_sum;
    logic signed [kf_pkg::DW-1:0]    w_wb;
    logic signed [kf_pkg::DW-1:0]    w_quot;
    logic                            w_div_done;

    function automatic logic signed [kf_pkg::DW-1:0] rd(input logic [kf_pkg::SEL_W-1:0] s,
                                                        input logic signed [kf_pkg::DW-1:0] v);
        return s[kf_pkg::SEL_W-1] ? '0 : v;
    endfunction

    function automatic logic signed [kf_pkg::DW-1:0] rst_val(input logic [4:0] idx);
        if (idx == kf_pkg::S_F00[4:0] || idx == kf_pkg::S_F01[4:0] ||
            idx == kf_pkg::S_F11[4:0] || idx == kf_pkg::S_H0[4:0] ||
            idx == kf_pkg::S_R[4:0]) begin
            return kf_pkg::ONE;
        end else if (idx == kf_pkg::S_P0[4:0] || idx == kf_pkg::S_P3[4:0]) begin
            return kf_pkg::INIT_RST;
        end
        return '0;
    endfunction

    assign w_opa = rd(i_cmd.sa, r_rf[i_cmd.sa[4:0]]);
    assign w_opb = rd(i_cmd.sb, r_rf[i_cmd.sb[4:0]]);
    assign w_ope = rd(i_cmd.se, r_rf[i_cmd.se[4:0]]);

    assign w_rnd64 = (r_prod + (64'sd1 <<< (kf_pkg::FRAC_BITS - 1))) >>> kf_pkg::FRAC_BITS;
    assign w_rnd   = kf_pkg::ACC_W'(w_rnd64);
    assign w_v     = kf_pkg::sat32(r_acc);
    assign w_sum   = i_cmd.neg ? ((kf_pkg::DW+1)'(w_ope) - (kf_pkg::DW+1)'(w_v))
                               : ((kf_pkg::DW+1)'(w_ope) + (kf_pkg::DW+1)'(w_v));
    assign w_wb    = kf_pkg::sat32(kf_pkg::ACC_W'(w_sum));

    kf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_opa),
        .i_den   (r_rf[kf_pkg::S_S[4:0]]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= 64'(w_opa) * 64'(w_opb);
        end
        if (i_cmd.ld) begin
            r_acc <= w_rnd;
        end else if (i_cmd.add) begin
            r_acc <= r_acc + w_rnd;
        end
        if (i_cmd.div_start) begin
            r_div_dst <= i_cmd.dst;
        end
        if (i_cmd.ld_out) begin
            r_res <= {r_rf[kf_pkg::S_P3[4:0]], r_rf[kf_pkg::S_P2[4:0]],
                      r_rf[kf_pkg::S_P1[4:0]], r_rf[kf_pkg::S_P0[4:0]],
                      r_rf[kf_pkg::S_X1[4:0]], r_rf[kf_pkg::S_X0[4:0]]};
            r_bad <= i_cmd.bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) begin
                r_rf[i] <= rst_val(5'(i));
            end
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    kf_pkg::CFG_F00, kf_pkg::CFG_F01, kf_pkg::CFG_F10,
                    kf_pkg::CFG_F11, kf_pkg::CFG_H0, kf_pkg::CFG_H1: begin
                        r_rf[5'(i_cfg_addr)] <= $signed(i_cfg_wdata);
                    end
                    kf_pkg::CFG_R: begin
                        r_rf[kf_pkg::S_R[4:0]] <= $signed({1'b0, i_cfg_wdata[30:0]});
                    end
                    kf_pkg::CFG_INIT: begin
                        r_rf[kf_pkg::S_X0[4:0]] <= '0;
                        r_rf[kf_pkg::S_X1[4:0]] <= '0;
                        r_rf[kf_pkg::S_P0[4:0]] <= $signed({1'b0, i_cfg_wdata[30:0]});
                        r_rf[kf_pkg::S_P1[4:0]] <= '0;
                        r_rf[kf_pkg::S_P2[4:0]] <= '0;
                        r_rf[kf_pkg::S_P3[4:0]] <= $signed({1'b0, i_cfg_wdata[30:0]});
                    end
                    default: ;
                endcase
            end
            if (i_cmd.ld_z) begin
                r_rf[kf_pkg::S_Z[4:0]] <= i_sample;
            end
            if (i_cmd.wr) begin
                r_rf[i_cmd.dst[4:0]] <= w_wb;
            end
            if (w_div_done) begin
                r_rf[r_div_dst[4:0]] <= w_quot;
            end
        end
    end

    assign o_stat.s_bad    = (r_rf[kf_pkg::S_S[4:0]] <= 0);
    assign o_stat.div_done = w_div_done;
    assign o_res = r_res;
    assign o_bad = r_bad;

endmodule

// ===== rtl/kf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kf_ctrl
// Micro-op sequencer: steps the update program, drives the datapath and owns
// the input and output handshakes.
// ----------------------------------------------------------------------------
module kf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  kf_pkg::t_stat i_stat,
    output kf_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DIVW = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [kf_pkg::PC_W-1:0] r_pc, n_pc;
    logic [1:0]              r_ph, n_ph;
    logic                    r_bad, n_bad;
    logic                    r_out_valid, n_out_valid;
    kf_pkg::t_uop            w_u;
    logic                    w_out_free;

    assign w_u        = kf_pkg::ucode(r_pc);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_ph        = r_ph;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.sa    = w_u.a0;
        o_cmd.sb    = w_u.b0;
        o_cmd.se    = w_u.e;
        o_cmd.dst   = w_u.dst;
        o_cmd.neg   = w_u.neg;
        o_cmd.bad   = r_bad;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_z = 1'b1;
                    n_pc       = '0;
                    n_ph       = '0;
                    n_bad      = 1'b0;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                unique case (w_u.op)
                    kf_pkg::OP_DOT: begin
                        unique case (r_ph)
                            2'd0: o_cmd.mul = 1'b1;
                            2'd1: begin
                                o_cmd.ld  = 1'b1;
                                o_cmd.mul = 1'b1;
                                o_cmd.sa  = w_u.a1;
                                o_cmd.sb  = w_u.b1;
                            end
                            2'd2: o_cmd.add = 1'b1;
                            default: begin
                                o_cmd.wr = 1'b1;
                                n_pc     = r_pc + 1'b1;
                            end
                        endcase
                        n_ph = r_ph + 1'b1;
                    end
                    kf_pkg::OP_CHK: begin
                        if (i_stat.s_bad) begin
                            n_bad   = 1'b1;
                            n_state = ST_OUT;
                        end else begin
                            n_pc = r_pc + 1'b1;
                        end
                    end
                    kf_pkg::OP_DIV: begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIVW;
                    end
                    default: n_state = ST_OUT;
                endcase
            end
            ST_DIVW: begin
                if (i_stat.div_done) begin
                    n_pc    = r_pc + 1'b1;
                    n_state = ST_RUN;
                end
            end
            default: begin
                if (w_out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pc        <= '0;
            r_ph        <= '0;
            r_bad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_ph        <= n_ph;
            r_bad       <= n_bad;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/kalman_filter_2state_1meas.sv =====
// ----------------------------------------------------------------------------
// kalman_filter_2state_1meas
// Two-state linear Kalman filter, scalar measurement, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Each beat on s_axis carries one measurement and runs one predict/update
// step; one beat on m_axis returns the new state, covariance and a flag
// that is set when the innovation variance is not positive (state kept).
// Coefficients are written on the cfg port while the filter is idle;
// writing init_uncert restarts the filter (state zero, diagonal covariance).
// Each step with S > 0 runs 22 multiply-accumulate micro-ops on one shared
// 32x32 multiplier, one check micro-op, one end micro-op, one output load
// and two divisions on a one-bit-per-cycle divider; with S <= 0 it stops
// after the check and loads the output. One measurement is in flight at a
// time: a new beat is taken only after the previous step has loaded its
// result.
// The result sits in an output register: a new measurement is taken while
// m_axis stalls, but the step cannot finish until the previous result is
// taken. Synchronous reset loads the default coefficients, zero state and
// a covariance of 100.0 on the diagonal.
// ----------------------------------------------------------------------------
module kalman_filter_2state_1meas (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [2:0]              i_cfg_addr,
    input  logic [31:0]             i_cfg_wdata,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,   // sample
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [191:0]            m_axis_tdata,   // pos_est, vel_est, cov_00..cov_11
    output logic [0:0]              m_axis_tuser    // bad_gain
);

    kf_pkg::t_cmd  w_cmd;
    kf_pkg::t_stat w_stat;
    logic          w_bad;

    kf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    kf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    ($signed(s_axis_tdata)),
        .o_res       (m_axis_tdata),
        .o_bad       (w_bad)
    );

    assign m_axis_tuser = w_bad;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a step was running");

    a_no_wb_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.wr && w_stat.div_done))
        else $error("write-back collides with divider result");

    a_acc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.ld && w_cmd.add))
        else $error("accumulator load and add together");

    a_out_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ld_out |=> m_axis_tvalid)
        else $error("result loaded without valid");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Regression bench for the two-state scalar-measurement Kalman filter.
// A behavioural predictor tracks state and covariance for every accepted
// measurement beat; a checker compares each result beat field by field.
// Coefficients are changed between phases while the filter is idle.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        bad;
        logic [31:0] c11, c10, c01, c00, vel, pos;
    } t_est;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wr_en = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [191:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    kalman_filter_2state_1meas i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    longint f00, f01, f10, f11, h0, h1, rn, p0init;
    longint xv[2];
    longint pm[4];
    t_est   est_q[$];
    int     errors = 0;
    bit     calm = 1'b0;
    int     idle_cycles = 0;
    int     stall_left = 0;

    function automatic longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint rmul(longint a, longint b);
        return (a * b + (64'sd1 <<< (kf_pkg::FRAC_BITS - 1))) >>> kf_pkg::FRAC_BITS;
    endfunction

    function automatic longint dot(longint a0, longint b0, longint a1, longint b1);
        return sat(rmul(a0, b0) + rmul(a1, b1));
    endfunction

    function automatic longint gain(longint c, longint s);
        longint unsigned mag, q;
        mag = (c < 0) ? -c : c;
        q = ((mag << kf_pkg::FRAC_BITS) + longint'(s) / 2) / s;
        if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
        return sat((c < 0) ? -longint'(q) : longint'(q));
    endfunction

    task automatic restart_filter();
        xv[0] = 0; xv[1] = 0;
        pm[0] = p0init; pm[1] = 0; pm[2] = 0; pm[3] = p0init;
    endtask

    function automatic t_est kalman_step(longint z);
        longint xp0, xp1, a0, a1, a2, a3, q0, q1, q2, q3;
        longint hp0, hp1, c0, c1, s, y, k0, k1;
        t_est r;
        xp0 = dot(f00, xv[0], f01, xv[1]);
        xp1 = dot(f10, xv[0], f11, xv[1]);
        a0 = dot(f00, pm[0], f01, pm[2]);
        a1 = dot(f00, pm[1], f01, pm[3]);
        a2 = dot(f10, pm[0], f11, pm[2]);
        a3 = dot(f10, pm[1], f11, pm[3]);
        q0 = dot(a0, f00, a1, f01);
        q1 = dot(a0, f10, a1, f11);
        q2 = dot(a2, f00, a3, f01);
        q3 = dot(a2, f10, a3, f11);
        hp0 = dot(h0, q0, h1, q2);
        hp1 = dot(h0, q1, h1, q3);
        c0 = dot(q0, h0, q1, h1);
        c1 = dot(q2, h0, q3, h1);
        s = sat(dot(hp0, h0, hp1, h1) + rn);
        y = sat(z - dot(h0, xp0, h1, xp1));
        r.bad = (s <= 0);
        if (!r.bad) begin
            k0 = gain(c0, s);
            k1 = gain(c1, s);
            xv[0] = sat(xp0 + sat(rmul(k0, y)));
            xv[1] = sat(xp1 + sat(rmul(k1, y)));
            pm[0] = sat(q0 - sat(rmul(k0, hp0)));
            pm[1] = sat(q1 - sat(rmul(k0, hp1)));
            pm[2] = sat(q2 - sat(rmul(k1, hp0)));
            pm[3] = sat(q3 - sat(rmul(k1, hp1)));
        end
        r.pos = xv[0][31:0]; r.vel = xv[1][31:0];
        r.c00 = pm[0][31:0]; r.c01 = pm[1][31:0];
        r.c10 = pm[2][31:0]; r.c11 = pm[3][31:0];
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task automatic hold_off(int n);
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, longint v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1; i_cfg_addr <= idx; i_cfg_wdata <= v[31:0];
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            kf_pkg::CFG_F00:  f00 = $signed(v[31:0]);
            kf_pkg::CFG_F01:  f01 = $signed(v[31:0]);
            kf_pkg::CFG_F10:  f10 = $signed(v[31:0]);
            kf_pkg::CFG_F11:  f11 = $signed(v[31:0]);
            kf_pkg::CFG_H0:   h0  = $signed(v[31:0]);
            kf_pkg::CFG_H1:   h1  = $signed(v[31:0]);
            kf_pkg::CFG_R:    rn  = v[30:0];
            default: begin
                p0init = v[30:0];
                restart_filter();
            end
        endcase
    endtask

    task automatic send_sample(logic [31:0] z);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            hold_off($urandom_range(1, 16));
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= z;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        est_q.push_back(kalman_step($signed(z)));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (est_q.size() != 0) @(posedge i_clk);
        hold_off(250);
    endtask

    task automatic set_coeffs(longint a, longint b, longint c, longint d,
                              longint e, longint g, longint r, longint p);
        write_reg(kf_pkg::CFG_F00, a); write_reg(kf_pkg::CFG_F01, b);
        write_reg(kf_pkg::CFG_F10, c); write_reg(kf_pkg::CFG_F11, d);
        write_reg(kf_pkg::CFG_H0, e);  write_reg(kf_pkg::CFG_H1, g);
        write_reg(kf_pkg::CFG_R, r);   write_reg(kf_pkg::CFG_INIT, p);
    endtask

    function automatic logic [31:0] rnd_sample();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    task automatic test_defaults();
        send_sample(32'h0000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_0000);
        send_sample(32'hFFFF_FFFF);
        drain();
    endtask

    task automatic test_bad_gain();
        // non-positive H*P*H' + R: gain is skipped and state held; the last phase uses extreme H and P
        set_coeffs(65536, 0, 0, 65536, 65536, 0, 0, 0);
        send_sample(32'h0005_0000);
        drain();
        write_reg(kf_pkg::CFG_R, 0);
        send_sample(32'h1234_5678);
        drain();
        set_coeffs(65536, 0, 0, 65536, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        drain();
    endtask

    task automatic test_extremes();
        set_coeffs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        repeat (4) send_sample(rnd_sample());
        drain();
        set_coeffs(0, 0, 0, 0, 0, 0, 1, 1);
        repeat (3) send_sample(rnd_sample());
        drain();
    endtask

    task automatic test_random(int phases, int per_phase);
        longint v;
        repeat (phases) begin
            if ($urandom_range(0, 3) == 0) begin
                set_coeffs($urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
            end else begin
                v = 65536 + $signed($urandom_range(0, 8192)) - 4096;
                set_coeffs(v, $urandom_range(0, 1) ? 65536 : $urandom_range(0, 8192),
                           $urandom_range(0, 1) ? 0 : $urandom_range(0, 4096),
                           65536 - $urandom_range(0, 4096),
                           65536, $urandom_range(0, 1) ? 0 : $urandom_range(0, 16384),
                           $urandom_range(1, 1 << 20), $urandom_range(1, 1 << 24));
            end
            repeat (per_phase) send_sample(rnd_sample());
            drain();
        end
    endtask

    always @(posedge i_clk) begin
        t_est got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser[0], m_axis_tdata};
                if (est_q.size() == 0) begin
                    errors++;
                    $display("unexpected result beat");
                end else begin
                    want = est_q.pop_front();
                    if (got.pos != want.pos) report("pos_est", got.pos, want.pos);
                    if (got.vel != want.vel) report("vel_est", got.vel, want.vel);
                    if (got.c00 != want.c00) report("cov_00", got.c00, want.c00);
                    if (got.c01 != want.c01) report("cov_01", got.c01, want.c01);
                    if (got.c10 != want.c10) report("cov_10", got.c10, want.c10);
                    if (got.c11 != want.c11) report("cov_11", got.c11, want.c11);
                    if (got.bad != want.bad)
                        report("bad_gain", 32'(got.bad), 32'(want.bad));
                end
            end
            m_axis_tready <= calm ? 1'b1 : (stall_left == 0);
        end
    end

    // stalls in bursts
    always @(posedge i_clk) begin
        if (!calm && stall_left == 0 && $urandom_range(0, 40) == 0)
            stall_left <= $urandom_range(1, 16);
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("kalman_filter_2state_1meas regression: fail");
            $finish;
        end
    end

    initial begin
        f00 = 65536; f01 = 65536; f10 = 0; f11 = 65536;
        h0 = 65536; h1 = 0; rn = 65536; p0init = 6553600;
        restart_filter();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_bad_gain();
        test_extremes();
        test_random(40, 28);
        calm = 1'b1;
        test_random(4, 30);
        if (errors == 0)
            $display("kalman_filter_2state_1meas regression: pass");
        else
            $display("kalman_filter_2state_1meas regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/kf_pkg.sv
rtl/kf_div.sv
rtl/kf_datapath.sv
rtl/kf_ctrl.sv
rtl/kalman_filter_2state_1meas.sv
tb/sv/tb.sv
